FILE: design/bpfa_pkg.sv
// Package for the bitmap page frame allocator.
// Holds the shared constants, status and request codes, and the find-first-zero helper.
// No dependencies.
package bpfa_pkg;

  localparam int WORD_BITS          = 64;
  localparam int BIT_AW             = 6;
  localparam int PAGE_SHIFT         = 12;
  localparam int ADDR_W             = 64;
  localparam int POOL_PAGES_DEFAULT = 64;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // Index of the lowest clear bit; only meaningful when some bit is clear.
  function automatic logic [BIT_AW-1:0] find_zero(input logic [WORD_BITS-1:0] word);
    logic [BIT_AW-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        pos = BIT_AW'(i);
      end
    end
    return pos;
  endfunction

endpackage

FILE: design/bpfa_ifs.sv
// Handshake interfaces for the request and response channels.
// Depends on bpfa_pkg for field widths.
interface bpfa_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [bpfa_pkg::ADDR_W-1:0]   free_addr;

  modport source (output valid, output req_type, output free_addr, input ready);
  modport sink   (input valid, input req_type, input free_addr, output ready);
endinterface

interface bpfa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bpfa_pkg::ADDR_W-1:0]   page_addr;
  logic [1:0]                    status;

  modport source (output valid, output page_addr, output status, input ready);
  modport sink   (input valid, input page_addr, input status, output ready);
endinterface

FILE: design/bitmap_page_frame_allocator_unit.sv
// Top level of the bitmap page frame allocator: sequencer, config register, result register.
// Depends on bpfa_pkg, bpfa_ifs (bpfa_req_if, bpfa_rsp_if), bpfa_addsub and bpfa_map.
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+-------------------------------
//   req      | in  | valid / ready        | req_type, free_addr
//   rsp      | out | valid / ready        | page_addr, status
//   cfg      | in  | cfg_wr_en, no ready  | cfg_wr_data -> pool_base
//
// Steps: an allocate scans the bitmap one word per cycle through the single map read port,
// then marks the found bit used and loads the response; a full pool responds after the last
// word. A free steps through subtract, range check with word read, then bit check and write;
// an address outside the pool responds from the range check. The sequencer is idle again once
// the response loads, ready to take the next request.
// Reset clears the bitmap at once through per-word valid bits; no clearing pass is needed.
// req.ready is high only while the sequencer is idle; a response stalled on rsp.ready holds
// the sequencer in its final step until the output register frees up.
module bitmap_page_frame_allocator_unit #(
  parameter int POOL_PAGES = bpfa_pkg::POOL_PAGES_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  bpfa_req_if.sink                    req,
  bpfa_rsp_if.source                  rsp,
  input  logic                        cfg_wr_en,
  input  logic [bpfa_pkg::ADDR_W-1:0] cfg_wr_data
);

  localparam int MAP_WORDS = (POOL_PAGES + bpfa_pkg::WORD_BITS - 1) / bpfa_pkg::WORD_BITS;
  localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PAGE_W    = $clog2(POOL_PAGES);
  localparam int LAST_BITS = POOL_PAGES - (MAP_WORDS - 1) * bpfa_pkg::WORD_BITS;
  localparam int HI_W      = bpfa_pkg::ADDR_W - bpfa_pkg::PAGE_SHIFT;
  localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(MAP_WORDS - 1);
  // Bits past the pool in the last word count as used during the scan.
  localparam logic [bpfa_pkg::WORD_BITS-1:0] PAD_MASK =
    (LAST_BITS == bpfa_pkg::WORD_BITS) ? '0 : ({bpfa_pkg::WORD_BITS{1'b1}} << LAST_BITS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_A_CHK = 3'd1;
  localparam logic [2:0] S_A_WR  = 3'd2;
  localparam logic [2:0] S_F_SUB = 3'd3;
  localparam logic [2:0] S_F_RNG = 3'd4;
  localparam logic [2:0] S_F_CHK = 3'd5;

  logic [2:0]                        state;
  logic [2:0]                        state_next;
  logic [bpfa_pkg::ADDR_W-1:0]       pool_base;
  logic [bpfa_pkg::ADDR_W-1:0]       req_addr;
  logic [WORD_AW-1:0]                word_ptr;
  logic [bpfa_pkg::BIT_AW-1:0]       bit_sel;
  logic [PAGE_W-1:0]                 page_idx;
  logic [bpfa_pkg::ADDR_W-1:0]       diff;
  logic                              below;

  // Map port
  logic                              rd_en;
  logic [WORD_AW-1:0]                rd_addr;
  logic [bpfa_pkg::WORD_BITS-1:0]    map_rdata;
  logic                              wr_en;
  logic [bpfa_pkg::WORD_BITS-1:0]    wr_data;

  // Shared adder
  logic [bpfa_pkg::ADDR_W-1:0]       add_a;
  logic [bpfa_pkg::ADDR_W-1:0]       add_b;
  logic                              add_sub;
  logic [bpfa_pkg::ADDR_W-1:0]       add_sum;
  logic                              add_carry;

  logic [bpfa_pkg::WORD_BITS-1:0]    masked;
  logic                              word_full;
  logic [bpfa_pkg::BIT_AW-1:0]       zero_pos;
  logic [PAGE_W-1:0]                 free_idx;
  logic                              free_bad;
  logic                              out_ok;
  logic                              out_load;
  logic [bpfa_pkg::ADDR_W-1:0]       out_addr_next;
  logic [1:0]                        out_status_next;
  logic                              accept;

  bpfa_map #(
    .MAP_WORDS (MAP_WORDS),
    .WORD_AW   (WORD_AW)
  ) u_map (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (map_rdata),
    .wr_en   (wr_en),
    .wr_addr (word_ptr),
    .wr_data (wr_data)
  );

  bpfa_addsub u_addsub (
    .a     (add_a),
    .b     (add_b),
    .sub   (add_sub),
    .sum   (add_sum),
    .carry (add_carry)
  );

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_ok    = !rsp.valid || rsp.ready;

  assign masked    = map_rdata | ((word_ptr == LAST_WORD) ? PAD_MASK : '0);
  assign word_full = &masked;
  assign zero_pos  = bpfa_pkg::find_zero(masked);

  // Page index of a free request and its range check against the pool.
  assign free_idx  = diff[bpfa_pkg::PAGE_SHIFT +: PAGE_W];
  assign free_bad  = below || (diff[bpfa_pkg::ADDR_W-1:bpfa_pkg::PAGE_SHIFT] >= HI_W'(POOL_PAGES));

  always_comb begin
    state_next      = state;
    rd_en           = 1'b0;
    rd_addr         = word_ptr;
    wr_en           = 1'b0;
    wr_data         = map_rdata;
    add_a           = pool_base;
    add_b           = bpfa_pkg::ADDR_W'(page_idx) << bpfa_pkg::PAGE_SHIFT;
    add_sub         = 1'b0;
    out_load        = 1'b0;
    out_addr_next   = '0;
    out_status_next = bpfa_pkg::ST_OK;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          // Start the first word read right away; a free simply ignores it.
          rd_en   = 1'b1;
          rd_addr = '0;
          state_next = (req.req_type == bpfa_pkg::REQ_FREE) ? S_F_SUB : S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (word_full) begin
          if (word_ptr == LAST_WORD) begin
            // Pool full: report and drop back to idle once the output is free.
            if (out_ok) begin
              out_load        = 1'b1;
              out_status_next = bpfa_pkg::ST_FULL;
              state_next      = S_IDLE;
            end
          end else begin
            // Advance the scan to the next word.
            rd_en   = 1'b1;
            rd_addr = word_ptr + 1'b1;
          end
        end else begin
          state_next = S_A_WR;
        end
      end
      S_A_WR: begin
        // Mark the page used and form pool_base + index * 4096. The write repeats
        // harmlessly while the output stalls since the read word holds.
        wr_en   = 1'b1;
        wr_data = map_rdata | ({{(bpfa_pkg::WORD_BITS-1){1'b0}}, 1'b1} << bit_sel);
        if (out_ok) begin
          out_load      = 1'b1;
          out_addr_next = add_sum;
          state_next    = S_IDLE;
        end
      end
      S_F_SUB: begin
        add_a      = req_addr;
        add_b      = pool_base;
        add_sub    = 1'b1;
        state_next = S_F_RNG;
      end
      S_F_RNG: begin
        rd_en   = 1'b1;
        rd_addr = WORD_AW'(free_idx >> bpfa_pkg::BIT_AW);
        if (free_bad) begin
          if (out_ok) begin
            out_load        = 1'b1;
            out_status_next = bpfa_pkg::ST_INVALID;
            state_next      = S_IDLE;
          end
        end else begin
          state_next = S_F_CHK;
        end
      end
      S_F_CHK: begin
        if (!map_rdata[bit_sel]) begin
          // Double free: leave the bitmap alone.
          if (out_ok) begin
            out_load        = 1'b1;
            out_status_next = bpfa_pkg::ST_INVALID;
            state_next      = S_IDLE;
          end
        end else begin
          wr_en   = 1'b1;
          wr_data = map_rdata & ~({{(bpfa_pkg::WORD_BITS-1){1'b0}}, 1'b1} << bit_sel);
          if (out_ok) begin
            out_load   = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pool_base <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        pool_base <= cfg_wr_data;
      end
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.page_addr <= out_addr_next;
      rsp.status    <= out_status_next;
    end
    if (accept) begin
      req_addr <= req.free_addr;
      word_ptr <= '0;
    end
    if (rd_en && state == S_A_CHK) begin
      word_ptr <= rd_addr;
    end
    if (state == S_A_CHK && !word_full) begin
      bit_sel  <= zero_pos;
      page_idx <= PAGE_W'({word_ptr, zero_pos});
    end
    if (state == S_F_SUB) begin
      diff  <= add_sum;
      below <= !add_carry;
    end
    if (state == S_F_RNG) begin
      page_idx <= free_idx;
      bit_sel  <= free_idx[bpfa_pkg::BIT_AW-1:0];
      word_ptr <= rd_addr;
    end
  end

endmodule

FILE: design/bpfa_addsub.sv
// Shared 64-bit add/subtract unit for address arithmetic.
// Depends on bpfa_pkg.
module bpfa_addsub (
  input  logic [bpfa_pkg::ADDR_W-1:0] a,
  input  logic [bpfa_pkg::ADDR_W-1:0] b,
  input  logic                        sub,
  output logic [bpfa_pkg::ADDR_W-1:0] sum,
  output logic                        carry
);

  logic [bpfa_pkg::ADDR_W-1:0] b_op;
  logic [bpfa_pkg::ADDR_W:0]   full;

  // Subtract as a + ~b + 1; carry out high means no borrow.
  assign b_op  = sub ? ~b : b;
  assign full  = {1'b0, a} + {1'b0, b_op} + {{bpfa_pkg::ADDR_W{1'b0}}, sub};
  assign sum   = full[bpfa_pkg::ADDR_W-1:0];
  assign carry = full[bpfa_pkg::ADDR_W];

endmodule

FILE: design/bpfa_map.sv
// Occupancy bitmap memory: one 64-bit word per entry, registered read.
// Per-word valid bits make unwritten words read as all free after reset.
// Depends on bpfa_pkg.
module bpfa_map #(
  parameter int MAP_WORDS = 1,
  parameter int WORD_AW   = 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           rd_en,
  input  logic [WORD_AW-1:0]             rd_addr,
  output logic [bpfa_pkg::WORD_BITS-1:0] rd_data,
  input  logic                           wr_en,
  input  logic [WORD_AW-1:0]             wr_addr,
  input  logic [bpfa_pkg::WORD_BITS-1:0] wr_data
);

  logic [bpfa_pkg::WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0]           word_valid;
  logic [bpfa_pkg::WORD_BITS-1:0] rd_word;
  logic                           rd_word_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid    <= '0;
      rd_word_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        word_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_word_valid <= word_valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_word_valid ? rd_word : '0;

endmodule

FILE: test/testbench.sv
// Testbench for bitmap_page_frame_allocator_unit: random and directed allocate/free requests,
// checked against an in-bench model of the occupancy bitmap and the pool base register.
// Depends on bpfa_pkg, the bpfa_req_if / bpfa_rsp_if interfaces and the allocator RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bpfa_pkg::*;

  localparam int POOL_PAGES = POOL_PAGES_DEFAULT;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] free_addr;
  } page_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] page_addr;
    logic [1:0]        status;
  } page_rsp_t;

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [ADDR_W-1:0] cfg_wr_data;

  bpfa_req_if req_ch ();
  bpfa_rsp_if rsp_ch ();

  bitmap_page_frame_allocator_unit #(
    .POOL_PAGES (POOL_PAGES)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Requests waiting for the driver, and responses the model says are owed.
  page_req_t pending_reqs[$];
  page_rsp_t owed_rsps[$];

  // Model state: one bit per page plus the pool base as last written.
  logic [POOL_PAGES-1:0] page_used_model;
  logic [ADDR_W-1:0]     pool_base_model;

  // Set by the driver when it puts a request on the channel, cleared on acceptance.
  bit in_flight;
  int burst_left;
  int gap_left;

  // Receiver stall pattern.
  int          ready_mode;
  int          ready_span;
  logic [15:0] ready_pattern;

  int error_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run of this stimulus.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // Work out the response to one request and advance the model bitmap.
  function automatic page_rsp_t predict_page_request(input page_req_t r);
    page_rsp_t         res;
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] page_idx;
    bit                found;
    res.page_addr = '0;
    res.status    = ST_OK;
    if (r.req_type == REQ_ALLOC) begin
      // Lowest free page wins; the address wraps mod 2^64 on purpose.
      found = 1'b0;
      for (int i = 0; i < POOL_PAGES; i++) begin
        if (!found && !page_used_model[i]) begin
          found              = 1'b1;
          page_used_model[i] = 1'b1;
          res.page_addr      = pool_base_model + (ADDR_W'(i) << PAGE_SHIFT);
        end
      end
      if (!found) res.status = ST_FULL;
    end else if (r.free_addr < pool_base_model) begin
      res.status = ST_INVALID;
    end else begin
      offset   = r.free_addr - pool_base_model;
      page_idx = offset >> PAGE_SHIFT;
      if (page_idx >= ADDR_W'(POOL_PAGES)) begin
        res.status = ST_INVALID;
      end else if (!page_used_model[page_idx]) begin
        // Double free: leave the bitmap alone.
        res.status = ST_INVALID;
      end else begin
        page_used_model[page_idx] = 1'b0;
      end
    end
    return res;
  endfunction

  // Build one random request. Frees mostly aim at pages inside the pool so that
  // they hit used pages; the rest is below-pool, past-pool and raw noise.
  function automatic page_req_t make_random_request(input int alloc_pct,
                                                    input logic [ADDR_W-1:0] base);
    page_req_t         r;
    logic [ADDR_W-1:0] noise;
    int                kind;
    noise       = {$urandom, $urandom};
    r.free_addr = noise;
    if ($urandom_range(0, 99) < alloc_pct) begin
      r.req_type = REQ_ALLOC;
    end else begin
      r.req_type = REQ_FREE;
      kind       = $urandom_range(0, 99);
      if (kind < 70) begin
        r.free_addr = base + (ADDR_W'($urandom_range(0, POOL_PAGES - 1)) << PAGE_SHIFT);
        if ($urandom_range(0, 1) == 1) r.free_addr = r.free_addr + ADDR_W'(noise[11:0]);
      end else if (kind < 80) begin
        r.free_addr = (base == '0) ? noise : noise % base;
      end else if (kind < 89) begin
        r.free_addr = base + (ADDR_W'(POOL_PAGES + $urandom_range(0, 3)) << PAGE_SHIFT)
                      + ADDR_W'(noise[11:0]);
      end else if (kind == 89) begin
        r.free_addr = '1;
      end
    end
    return r;
  endfunction

  function automatic void queue_request(input logic rt, input logic [ADDR_W-1:0] addr);
    page_req_t r;
    r.req_type  = rt;
    r.free_addr = addr;
    pending_reqs.push_back(r);
  endfunction

  // Hold until the driver has nothing left and every owed response is back.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_flight || owed_rsps.size() != 0) @(negedge clk);
  endtask

  task automatic write_pool_base(input logic [ADDR_W-1:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // One pool base setting followed by a run of random requests. Each phase
  // opens alloc-heavy to push the pool toward full, then mixes the ratio per
  // chunk. Halfway through, the sender pauses until the block has drained.
  task automatic run_phase(input logic [ADDR_W-1:0] base, input int n_items);
    int alloc_pct;
    write_pool_base(base);
    alloc_pct = 90;
    for (int i = 0; i < n_items; i++) begin
      if (i >= 80 && i % 30 == 0) begin
        case ($urandom_range(0, 2))
          0:       alloc_pct = 85;
          1:       alloc_pct = 50;
          default: alloc_pct = 15;
        endcase
      end
      if (i == n_items / 2) wait_drained();
      pending_reqs.push_back(make_random_request(alloc_pct, base));
    end
  endtask

  // Stimulus and end of run.
  initial begin
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = REQ_ALLOC;
    req_ch.free_addr = '0;
    rsp_ch.ready     = 1'b0;
    error_count      = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: base at zero.
    write_pool_base('0);
    queue_request(REQ_ALLOC, '0);
    queue_request(REQ_ALLOC, '0);
    queue_request(REQ_ALLOC, '0);
    queue_request(REQ_FREE, 64'h0000_0000_0000_1fff);  // unaligned, frees page 1
    queue_request(REQ_FREE, 64'h0000_0000_0000_1000);  // double free
    queue_request(REQ_ALLOC, '0);                      // reuses page 1
    queue_request(REQ_FREE, '1);                       // far past the pool
    queue_request(REQ_FREE, 64'h0000_0000_0004_0000);  // first page past the pool
    queue_request(REQ_FREE, 64'h0000_0000_0003_f000);  // last page, never used
    queue_request(REQ_FREE, '0);                       // page 0
    queue_request(REQ_ALLOC, '1);                      // free_addr ignored
    // Directed: base at the top of the address space, so addresses wrap.
    write_pool_base(64'hffff_ffff_ffff_f000);
    queue_request(REQ_ALLOC, '0);
    queue_request(REQ_FREE, '0);                       // below the pool
    queue_request(REQ_FREE, 64'hffff_ffff_ffff_f000);  // page 0
    queue_request(REQ_FREE, '1);                       // same page, now double free
    queue_request(REQ_ALLOC, '0);

    // Random phases, the extreme bases kept short.
    run_phase(64'h0000_0000_8000_0000, 350);
    run_phase('0, 350);
    run_phase({$urandom, 20'($urandom), 12'h000}, 350);
    run_phase('1, 100);
    run_phase({$urandom, $urandom}, 350);
    run_phase(64'hffff_ffff_ffff_f000, 100);
    run_phase(64'h0000_0000_0000_1000, 350);

    // Let any stray response show up before the verdict.
    wait_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Request driver: bursts of random length separated by random gaps, with
  // some bursts running back to back. Advance only once the current request
  // has been taken.
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      burst_left   = 0;
      gap_left     = 0;
    end else if (!in_flight) begin
      if (gap_left > 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        page_req_t nxt;
        nxt              = pending_reqs.pop_front();
        in_flight        = 1'b1;
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= nxt.req_type;
        req_ch.free_addr <= nxt.free_addr;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Response ready: spans of always-ready mix at random with spans that follow a
  // rotating random pattern.
  always @(negedge clk) begin
    if (ready_span == 0) begin
      ready_span    = $urandom_range(50, 300);
      ready_mode    = $urandom_range(0, 2);
      ready_pattern = 16'($urandom) | 16'h0001;
    end else begin
      ready_span--;
    end
    rsp_ch.ready  <= (ready_mode == 0) ? 1'b1 : ready_pattern[0];
    ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
  end

  // Monitor: track config writes, predict on every accepted request, and
  // check every accepted response against the oldest owed one.
  always @(posedge clk) begin
    if (rst) begin
      page_used_model = '0;
      pool_base_model = '0;
      owed_rsps.delete();
      in_flight       = 1'b0;
    end else begin
      page_req_t acc;
      page_rsp_t got;
      page_rsp_t want;
      if (cfg_wr_en) pool_base_model = cfg_wr_data;
      if (req_ch.valid && req_ch.ready) begin
        acc.req_type  = req_ch.req_type;
        acc.free_addr = req_ch.free_addr;
        owed_rsps.push_back(predict_page_request(acc));
        in_flight     = 1'b0;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.page_addr = rsp_ch.page_addr;
        got.status    = rsp_ch.status;
        if (owed_rsps.size() == 0) begin
          $display("%0t: unexpected response, expected none, got page_addr %h status %0d",
                   $time, got.page_addr, got.status);
          error_count++;
        end else begin
          want = owed_rsps.pop_front();
          if (got.page_addr !== want.page_addr) begin
            $display("%0t: page_addr mismatch, expected %h, got %h",
                     $time, want.page_addr, got.page_addr);
            error_count++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, got.status);
            error_count++;
          end
        end
      end
    end
  end

endmodule

FILE: sim.f
design/bpfa_pkg.sv
design/bpfa_ifs.sv
design/bpfa_addsub.sv
design/bpfa_map.sv
design/bitmap_page_frame_allocator_unit.sv
test/testbench.sv
